// ----- rtl/rmb_pkg.sv -----
package rmb_pkg;

  // Register and dimension widths
  localparam int unsigned DimW      = 13;
  localparam int unsigned MaxWidth  = 4096;
  localparam int unsigned MaxHeight = 4096;
  localparam int unsigned ColW      = $clog2(MaxWidth);
  localparam int unsigned RowW      = $clog2(MaxHeight);
  localparam int unsigned WidW      = (DimW > ColW + 1) ? DimW : ColW + 1;

  // Pixel lanes: four channels, each kept in a 9-bit lane for pair sums
  localparam int unsigned ChanW = 8;
  localparam int unsigned LaneW = 9;
  localparam int unsigned Lanes = 4;
  localparam int unsigned SumW  = Lanes * LaneW;

  // Configuration port
  localparam int unsigned DataW    = 32;
  localparam int unsigned RegIdxW  = 2;
  localparam int unsigned CfgAddrW = RegIdxW + 2;

  typedef enum logic [RegIdxW-1:0] {
    RegSrcWidth  = 2'd0,
    RegSrcHeight = 2'd1,
    RegTgtWidth  = 2'd2,
    RegTgtHeight = 2'd3
  } reg_e;

  typedef enum logic [1:0] {
    ModePass,
    ModeHoriz,
    ModeVert,
    ModeQuad
  } mode_e;

  // Item in flight between the input side and the result register
  typedef struct packed {
    mode_e             mode;
    logic              last;
    logic [SumW-1:0]   sum;
  } stage_t;

  // Add four 9-bit lanes, each wrapping at 9 bits
  function automatic logic [SumW-1:0] lane_add(logic [SumW-1:0] a, logic [SumW-1:0] b);
    logic [SumW-1:0] r;
    r = '0;
    for (int i = 0; i < Lanes; i++) begin
      r[i*LaneW +: LaneW] = a[i*LaneW +: LaneW] + b[i*LaneW +: LaneW];
    end
    return r;
  endfunction

endpackage

// ----- rtl/rmb_if.sv -----
interface rmb_pix_in_if
  import rmb_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ChanW-1:0] red_in;
  logic [ChanW-1:0] green_in;
  logic [ChanW-1:0] blue_in;
  logic [ChanW-1:0] alpha_in;

  modport source (output valid, red_in, green_in, blue_in, alpha_in, input ready);
  modport sink (input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

interface rmb_pix_out_if
  import rmb_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ChanW-1:0] red_out;
  logic [ChanW-1:0] green_out;
  logic [ChanW-1:0] blue_out;
  logic [ChanW-1:0] alpha_out;
  logic             frame_last;

  modport source (output valid, red_out, green_out, blue_out, alpha_out, frame_last,
                  input ready);
  modport sink (input valid, red_out, green_out, blue_out, alpha_out, frame_last,
                output ready);
endinterface

// ----- rtl/rmb_ram.sv -----
module rmb_ram #(
  parameter int unsigned Width = 36,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, held while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/rgba_mip_box_reduce.sv -----
// Channel    Dir  Handshake             Beat contents
// pix_in     in   valid/ready           red_in, green_in, blue_in, alpha_in
// pix_out    out  valid/ready           red_out, green_out, blue_out, alpha_out, frame_last
// apb        in   psel/penable/pready   paddr, pwdata, prdata (4 registers at 4*i)
//
// One pixel per clock while pix_out is not stalled. A pixel that yields a result passes
// one stage register, then the result register, before it shows on pix_out. The line
// store is one RAM with a write and a registered read port, both used in the input cycle.
// Reset clears counters, the pipeline and sets all size registers to 1; the line store
// is not cleared. A stall on pix_out backs up through both stages and, if a pixel is
// staged, drops pix_in.ready in the same cycle. A register write restarts the frame.
module rgba_mip_box_reduce
  import rmb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  rmb_pix_in_if.sink          pix_in,
  rmb_pix_out_if.source       pix_out,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [DataW-1:0]    pwdata,
  output logic [DataW-1:0]    prdata,
  output logic                pready
);

  // Configuration registers
  logic [DimW-1:0] src_w_q, src_h_q, tgt_w_q, tgt_h_q;
  logic            cfg_we;
  reg_e            cfg_idx;

  // Frame position and pair accumulator
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic [SumW-1:0] held_q, held_d;

  // Pipeline
  logic            s1_valid_q, s1_valid_d;
  stage_t          s1_q, s1_d;
  logic            out_valid_q, out_valid_d;
  logic [ChanW-1:0] red_q, green_q, blue_q, alpha_q;
  logic            last_q;
  logic [ChanW-1:0] res_chan [Lanes];

  // Decode of the current pixel
  logic [WidW-1:0] w_eff, w_even, ow, x_wide, col_p1;
  logic [DimW-1:0] h_eff, h_even, oh, y_wide, row_p1;
  logic            red_w, red_h, x_in, y_in;
  logic            x_half_last, y_half_last, x_end, y_end;
  mode_e           mode;
  logic [SumW-1:0] pix, pair;
  logic            emit, last, store_we;
  logic [ColW-1:0] ram_addr;
  logic [SumW-1:0] ram_wdata, ram_rdata;

  logic            en_out, in_ready, accept;

  // APB port
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = reg_e'(paddr[CfgAddrW-1:2]);

  always_comb begin
    prdata = '0;
    case (cfg_idx)
      RegSrcWidth:  prdata = DataW'(src_w_q);
      RegSrcHeight: prdata = DataW'(src_h_q);
      RegTgtWidth:  prdata = DataW'(tgt_w_q);
      RegTgtHeight: prdata = DataW'(tgt_h_q);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= DimW'(1);
      src_h_q <= DimW'(1);
      tgt_w_q <= DimW'(1);
      tgt_h_q <= DimW'(1);
    end else if (cfg_we) begin
      case (cfg_idx)
        RegSrcWidth:  src_w_q <= pwdata[DimW-1:0];
        RegSrcHeight: src_h_q <= pwdata[DimW-1:0];
        RegTgtWidth:  tgt_w_q <= pwdata[DimW-1:0];
        RegTgtHeight: tgt_h_q <= pwdata[DimW-1:0];
        default: ;
      endcase
    end
  end

  // Clamp sizes and pick the reduction mode
  always_comb begin
    if (src_w_q == '0) begin
      w_eff = WidW'(1);
    end else if (WidW'(src_w_q) > WidW'(MaxWidth)) begin
      w_eff = WidW'(MaxWidth);
    end else begin
      w_eff = WidW'(src_w_q);
    end
    if (src_h_q == '0) begin
      h_eff = DimW'(1);
    end else if (src_h_q > DimW'(MaxHeight)) begin
      h_eff = DimW'(MaxHeight);
    end else begin
      h_eff = src_h_q;
    end
    red_w = w_eff > WidW'(tgt_w_q);
    red_h = h_eff > tgt_h_q;
    if (red_w && red_h) begin
      mode = ModeQuad;
    end else if (red_w) begin
      mode = ModeHoriz;
    end else if (red_h) begin
      mode = ModeVert;
    end else begin
      mode = ModePass;
    end
  end

  // Position tests for the incoming pixel
  always_comb begin
    w_even      = {w_eff[WidW-1:1], 1'b0};
    h_even      = {h_eff[DimW-1:1], 1'b0};
    ow          = w_eff >> 1;
    oh          = h_eff >> 1;
    x_wide      = WidW'(col_q);
    y_wide      = DimW'(row_q);
    x_in        = x_wide < w_even;
    y_in        = y_wide < h_even;
    x_half_last = (x_wide >> 1) == ow - WidW'(1);
    y_half_last = (y_wide >> 1) == oh - DimW'(1);
    x_end       = x_wide == w_eff - WidW'(1);
    y_end       = y_wide == h_eff - DimW'(1);
  end

  // Per-pixel work: pair sums, line store access, result selection
  always_comb begin
    pix = {1'b0, pix_in.alpha_in, 1'b0, pix_in.blue_in,
           1'b0, pix_in.green_in, 1'b0, pix_in.red_in};
    pair      = lane_add(held_q, pix);
    held_d    = held_q;
    store_we  = 1'b0;
    ram_wdata = pix;
    emit      = 1'b0;
    last      = 1'b0;
    s1_d.sum  = pix;
    ram_addr  = (mode == ModeQuad) ? (col_q >> 1) : col_q;
    case (mode)
      ModeQuad: begin
        if (x_in && y_in) begin
          if (!col_q[0]) begin
            held_d = pix;
          end else begin
            held_d   = pair;
            s1_d.sum = pair;
            if (!row_q[0]) begin
              store_we  = 1'b1;
              ram_wdata = pair;
            end else begin
              emit = 1'b1;
              last = x_half_last && y_half_last;
            end
          end
        end
      end
      ModeHoriz: begin
        if (x_in) begin
          if (!col_q[0]) begin
            held_d = pix;
          end else begin
            held_d   = pair;
            s1_d.sum = pair;
            emit     = 1'b1;
            last     = x_half_last && y_end;
          end
        end
      end
      ModeVert: begin
        if (y_in) begin
          if (!row_q[0]) begin
            store_we = 1'b1;
          end else begin
            emit = 1'b1;
            last = x_end && y_half_last;
          end
        end
      end
      ModePass: begin
        emit = 1'b1;
        last = x_end && y_end;
      end
      default: ;
    endcase
    s1_d.mode = mode;
    s1_d.last = last;
  end

  // Advance raster position, wrap at row and frame end
  always_comb begin
    col_p1 = x_wide + WidW'(1);
    row_p1 = y_wide + DimW'(1);
    col_d  = col_q;
    row_d  = row_q;
    if (cfg_we) begin
      col_d = '0;
      row_d = '0;
    end else if (accept) begin
      if (col_p1 >= w_eff) begin
        col_d = '0;
        row_d = (row_p1 >= h_eff) ? '0 : row_p1[RowW-1:0];
      end else begin
        col_d = col_p1[ColW-1:0];
      end
    end
  end

  // Handshakes
  assign en_out       = !out_valid_q || pix_out.ready;
  assign in_ready     = !s1_valid_q || en_out;
  assign accept       = pix_in.valid && in_ready;
  assign pix_in.ready = in_ready;

  assign s1_valid_d  = in_ready ? (accept && emit) : s1_valid_q;
  assign out_valid_d = en_out ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      held_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      col_q       <= col_d;
      row_q       <= row_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (accept) begin
        held_q <= held_d;
      end
    end
  end

  // Line store: pair sums or pixels of the even row
  rmb_ram #(
    .Width(SumW),
    .Depth(MaxWidth)
  ) u_line_store (
    .clk_i  (clk_i),
    .we_i   (accept && store_we),
    .waddr_i(ram_addr),
    .wdata_i(ram_wdata),
    .re_i   (accept),
    .raddr_i(ram_addr),
    .rdata_o(ram_rdata)
  );

  // Combine with the line above and scale per mode
  always_comb begin
    logic [LaneW:0] vsum;
    for (int i = 0; i < Lanes; i++) begin
      vsum = {1'b0, ram_rdata[i*LaneW +: LaneW]} + {1'b0, s1_q.sum[i*LaneW +: LaneW]};
      case (s1_q.mode)
        ModeQuad:  res_chan[i] = vsum[LaneW:2];
        ModeVert:  res_chan[i] = vsum[LaneW-1:1];
        ModeHoriz: res_chan[i] = s1_q.sum[i*LaneW+1 +: ChanW];
        ModePass:  res_chan[i] = s1_q.sum[i*LaneW +: ChanW];
        default:   res_chan[i] = s1_q.sum[i*LaneW +: ChanW];
      endcase
    end
  end

  // Stage and result payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
    if (en_out && s1_valid_q) begin
      red_q   <= res_chan[0];
      green_q <= res_chan[1];
      blue_q  <= res_chan[2];
      alpha_q <= res_chan[3];
      last_q  <= s1_q.last;
    end
  end

  assign pix_out.valid      = out_valid_q;
  assign pix_out.red_out    = red_q;
  assign pix_out.green_out  = green_q;
  assign pix_out.blue_out   = blue_q;
  assign pix_out.alpha_out  = alpha_q;
  assign pix_out.frame_last = last_q;

endmodule
